/* rtl/kti_pkg.sv */
// Shared types, constants and helpers of the keyframe track interpolator.
`default_nettype none
package kti_pkg;

    localparam int KEYS_PER_TRACK = 64;
    localparam int TRACKS         = 6;
    localparam int TRACK_W        = 3;
    localparam int COUNT_W        = 7;
    localparam int IDX_W          = $clog2(KEYS_PER_TRACK + 1);
    localparam int KEY_W          = $clog2(KEYS_PER_TRACK);
    localparam int SLOTS          = TRACKS * KEYS_PER_TRACK;
    localparam int ADDR_W         = $clog2(SLOTS);
    localparam int TIME_W         = 24;
    localparam int VAL_W          = 32;
    localparam int ENTRY_W        = TIME_W + VAL_W;
    localparam int CLOCK_W        = 32;
    localparam int ELAPSED_W      = 16;
    localparam int NOW_W          = CLOCK_W + 1;
    localparam int DIST_W         = NOW_W + 1;
    localparam int MAG_W          = VAL_W + 1;
    localparam int PROD_W         = 48;
    localparam int STEP_W         = $clog2(PROD_W);

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_START  = 2'd2,
        MODE_REWIND = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_APPLY,
        ST_FINAL,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic [2:0]           channel;
        logic [5:0]           key_index;
        logic [TIME_W-1:0]    key_time;
        logic signed [VAL_W-1:0] key_value;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] pos_z;
        logic signed [VAL_W-1:0] yaw_now;
        logic signed [VAL_W-1:0] pitch_now;
        logic signed [VAL_W-1:0] roll_now;
        logic                    done_res;
    } result_t;

    // Load channels list pitch before yaw; tracks are stored x, y, z, yaw, pitch, roll.
    function automatic logic [TRACK_W-1:0] track_of(input logic [2:0] channel);
        logic [TRACK_W-1:0] tr;
        case (channel)
            3'd0:    tr = 3'd0;
            3'd1:    tr = 3'd1;
            3'd2:    tr = 3'd2;
            3'd3:    tr = 3'd4;
            3'd4:    tr = 3'd3;
            3'd5:    tr = 3'd5;
            default: tr = 3'd0;
        endcase
        return tr;
    endfunction

endpackage
`default_nettype wire

/* rtl/keyframe_track_interpolator.sv */
// Top level of the keyframe track interpolator: sequencer, track state and shared divider.
`default_nettype none
// Six tracks (x, y, z, yaw, pitch, roll) each hold up to 64 keyframes of an absolute time
// in ms and a signed Q16.16 value, kept in one keyframe RAM. Every input transfer yields
// exactly one result transfer with all six current values and the finished flag. A tick
// walks the tracks one after another: each key visited passes a RAM read, then an
// evaluate step, and a track that stops between two keys goes on through the shared
// multiply, the bit-serial divider (one quotient bit a cycle over 48 bits) and the final
// add. The input stalls while an item is in work; a finished result waits in the output
// register and does not hold up the next input transfer. Key slots that were never
// loaded read back undefined; counts above 64 act as 64.
module keyframe_track_interpolator (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire kti_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output kti_pkg::result_t       result,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [kti_pkg::COUNT_W-1:0] cfg_data
);

    localparam int TR = kti_pkg::TRACKS;

    kti_pkg::state_t state_reg, state_next;

    logic [kti_pkg::TRACK_W-1:0]   t_reg, t_next;
    logic [kti_pkg::ELAPSED_W-1:0] rem_reg, rem_next;
    logic [kti_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [kti_pkg::NOW_W-1:0]     now_reg, now_next;
    logic                          walk_reg, walk_next;
    logic [kti_pkg::IDX_W-1:0]     idx_reg [TR];
    logic [kti_pkg::IDX_W-1:0]     idx_next [TR];
    logic signed [kti_pkg::VAL_W-1:0] val_reg [TR];
    logic signed [kti_pkg::VAL_W-1:0] val_next [TR];
    logic [kti_pkg::COUNT_W-1:0]   cnt_reg [TR];
    logic [kti_pkg::IDX_W-1:0]     eff_cnt [TR];
    logic [kti_pkg::CLOCK_W-1:0]   clock_reg, clock_next;
    logic                          running_reg, running_next;
    logic                          finished_reg, finished_next;
    logic [kti_pkg::TIME_W-1:0]    d_reg, d_next;
    logic                          neg_reg, neg_next;
    logic [kti_pkg::MAG_W-1:0]     mag_reg, mag_next;
    logic [kti_pkg::PROD_W-1:0]    num_reg, num_next;
    logic [kti_pkg::TIME_W-1:0]    part_reg, part_next;
    logic [kti_pkg::STEP_W-1:0]    step_reg, step_next;
    kti_pkg::result_t              result_reg, result_next;
    logic                          result_valid_reg, result_valid_next;

    // Keyframe RAM signals.
    logic                          ram_we;
    logic [kti_pkg::ADDR_W-1:0]    ram_waddr;
    logic [kti_pkg::ADDR_W-1:0]    ram_raddr;
    logic                          ram_re;
    logic [kti_pkg::ENTRY_W-1:0]   ram_rdata;

    logic                          accept;
    logic                          all_done;
    logic [kti_pkg::TIME_W-1:0]    key_t;
    logic signed [kti_pkg::VAL_W-1:0] key_v;
    logic signed [kti_pkg::DIST_W-1:0] key_dist;
    logic signed [kti_pkg::DIST_W-1:0] rem_ext;
    logic signed [kti_pkg::MAG_W-1:0]  diff;
    logic [kti_pkg::TIME_W:0]      shifted;
    logic                          ge;
    logic signed [kti_pkg::MAG_W:0] delta;
    logic signed [kti_pkg::MAG_W:0] sum;
    logic                          last_track;
    logic                          load_ok;

    assign accept       = item_valid && !item_stall;
    assign item_stall   = (state_reg != kti_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A load writes its slot right at the transfer; bad channels and slots are dropped.
    assign load_ok   = (int'(item.channel) < TR)
                       && (int'(item.key_index) < kti_pkg::KEYS_PER_TRACK);
    assign ram_we    = accept && (kti_pkg::mode_t'(item.mode) == kti_pkg::MODE_LOAD) && load_ok;
    assign ram_waddr = kti_pkg::ADDR_W'(kti_pkg::track_of(item.channel))
                       * kti_pkg::ADDR_W'(kti_pkg::KEYS_PER_TRACK)
                       + kti_pkg::ADDR_W'(item.key_index);
    assign ram_re    = (state_reg == kti_pkg::ST_READ);
    assign ram_raddr = kti_pkg::ADDR_W'(t_reg) * kti_pkg::ADDR_W'(kti_pkg::KEYS_PER_TRACK)
                       + kti_pkg::ADDR_W'(idx_reg[t_reg][kti_pkg::KEY_W-1:0]);

    kti_ram #(
        .WIDTH(kti_pkg::ENTRY_W),
        .DEPTH(kti_pkg::SLOTS)
    ) u_key_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata({item.key_time, item.key_value}),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign key_t = ram_rdata[kti_pkg::ENTRY_W-1:kti_pkg::VAL_W];
    assign key_v = $signed(ram_rdata[kti_pkg::VAL_W-1:0]);

    // Signed distance from the walk's current time to the key under evaluation.
    assign key_dist = $signed({{(kti_pkg::DIST_W-kti_pkg::TIME_W){1'b0}}, key_t})
                      - $signed({1'b0, now_reg});
    assign rem_ext  = $signed({{(kti_pkg::DIST_W-kti_pkg::ELAPSED_W){1'b0}}, rem_reg});
    assign diff     = $signed({key_v[kti_pkg::VAL_W-1], key_v})
                      - $signed({val_reg[t_reg][kti_pkg::VAL_W-1], val_reg[t_reg]});

    // One restoring division step.
    assign shifted = {part_reg, num_reg[kti_pkg::PROD_W-1]};
    assign ge      = (shifted >= {1'b0, d_reg});

    // Quotient magnitude stays below 2^33, so its low bits carry the whole value.
    assign delta = neg_reg ? -$signed({1'b0, num_reg[kti_pkg::MAG_W-1:0]})
                           :  $signed({1'b0, num_reg[kti_pkg::MAG_W-1:0]});
    assign sum   = $signed({{2{val_reg[t_reg][kti_pkg::VAL_W-1]}}, val_reg[t_reg]}) + delta;

    assign last_track = (int'(t_reg) == TR - 1);

    always_comb
    begin
        all_done = 1'b1;
        for (int i = 0; i < TR; i++)
        begin
            eff_cnt[i] = (int'(cnt_reg[i]) > kti_pkg::KEYS_PER_TRACK)
                         ? kti_pkg::IDX_W'(kti_pkg::KEYS_PER_TRACK)
                         : kti_pkg::IDX_W'(cnt_reg[i]);
            if (idx_reg[i] < eff_cnt[i])
            begin
                all_done = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kti_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        t_next            = t_reg;
        rem_next          = rem_reg;
        elapsed_next      = elapsed_reg;
        now_next          = now_reg;
        walk_next         = walk_reg;
        idx_next          = idx_reg;
        val_next          = val_reg;
        clock_next        = clock_reg;
        running_next      = running_reg;
        finished_next     = finished_reg;
        d_next            = d_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        num_next          = num_reg;
        part_next         = part_reg;
        step_next         = step_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (state_reg)
            kti_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = kti_pkg::ST_PUBLISH;
                    case (kti_pkg::mode_t'(item.mode))
                        kti_pkg::MODE_TICK:
                        begin
                            elapsed_next = item.elapsed_ms;
                            rem_next     = item.elapsed_ms;
                            now_next     = {1'b0, clock_reg};
                            t_next       = '0;
                            walk_next    = running_reg && !finished_reg;
                            state_next   = (running_reg && !finished_reg)
                                           ? kti_pkg::ST_READ : kti_pkg::ST_FINAL;
                        end
                        kti_pkg::MODE_LOAD:
                        begin
                            state_next = kti_pkg::ST_PUBLISH;
                        end
                        kti_pkg::MODE_START,
                        kti_pkg::MODE_REWIND:
                        begin
                            if (kti_pkg::mode_t'(item.mode) == kti_pkg::MODE_REWIND)
                            begin
                                for (int i = 0; i < TR; i++)
                                begin
                                    idx_next[i] = '0;
                                end
                            end
                            clock_next    = '0;
                            finished_next = 1'b0;
                            running_next  = 1'b1;
                        end
                        default:
                        begin
                            state_next = kti_pkg::ST_PUBLISH;
                        end
                    endcase
                end
            end

            kti_pkg::ST_READ:
            begin
                // The RAM read is issued here unconditionally; it is used only if the walk goes on.
                if ((idx_reg[t_reg] < eff_cnt[t_reg]) && (rem_reg != '0))
                begin
                    state_next = kti_pkg::ST_EVAL;
                end
                else if (last_track)
                begin
                    state_next = kti_pkg::ST_FINAL;
                end
                else
                begin
                    t_next   = t_reg + 1'b1;
                    rem_next = elapsed_reg;
                    now_next = {1'b0, clock_reg};
                end
            end

            kti_pkg::ST_EVAL:
            begin
                if (key_dist > rem_ext)
                begin
                    d_next     = key_dist[kti_pkg::TIME_W-1:0];
                    neg_next   = diff[kti_pkg::MAG_W-1];
                    mag_next   = diff[kti_pkg::MAG_W-1] ? kti_pkg::MAG_W'(-diff)
                                                        : kti_pkg::MAG_W'(diff);
                    state_next = kti_pkg::ST_MUL;
                end
                else
                begin
                    val_next[t_reg] = key_v;
                    idx_next[t_reg] = idx_reg[t_reg] + 1'b1;
                    if (key_dist == rem_ext)
                    begin
                        // Key reached exactly: this track is done for the tick.
                        if (last_track)
                        begin
                            state_next = kti_pkg::ST_FINAL;
                        end
                        else
                        begin
                            t_next     = t_reg + 1'b1;
                            rem_next   = elapsed_reg;
                            now_next   = {1'b0, clock_reg};
                            state_next = kti_pkg::ST_READ;
                        end
                    end
                    else
                    begin
                        // Key already due or passed within the time left.
                        if (!key_dist[kti_pkg::DIST_W-1] && (key_dist != '0))
                        begin
                            rem_next = rem_reg - key_dist[kti_pkg::ELAPSED_W-1:0];
                            now_next = now_reg
                                       + kti_pkg::NOW_W'(key_dist[kti_pkg::ELAPSED_W-1:0]);
                        end
                        state_next = kti_pkg::ST_READ;
                    end
                end
            end

            kti_pkg::ST_MUL:
            begin
                num_next   = kti_pkg::PROD_W'(mag_reg * rem_reg);
                part_next  = '0;
                step_next  = '0;
                state_next = kti_pkg::ST_DIV;
            end

            kti_pkg::ST_DIV:
            begin
                part_next = ge ? kti_pkg::TIME_W'(shifted - {1'b0, d_reg})
                               : kti_pkg::TIME_W'(shifted);
                num_next  = {num_reg[kti_pkg::PROD_W-2:0], ge};
                step_next = step_reg + 1'b1;
                if (int'(step_reg) == kti_pkg::PROD_W - 1)
                begin
                    state_next = kti_pkg::ST_APPLY;
                end
            end

            kti_pkg::ST_APPLY:
            begin
                val_next[t_reg] = sum[kti_pkg::VAL_W-1:0];
                if (last_track)
                begin
                    state_next = kti_pkg::ST_FINAL;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    rem_next   = elapsed_reg;
                    now_next   = {1'b0, clock_reg};
                    state_next = kti_pkg::ST_READ;
                end
            end

            kti_pkg::ST_FINAL:
            begin
                if (walk_reg)
                begin
                    clock_next = clock_reg + kti_pkg::CLOCK_W'(elapsed_reg);
                end
                if (all_done)
                begin
                    finished_next = 1'b1;
                end
                state_next = kti_pkg::ST_PUBLISH;
            end

            kti_pkg::ST_PUBLISH:
            begin
                // Wait until the output register is free, then hand over a snapshot.
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.pos_x     = val_reg[0];
                    result_next.pos_y     = val_reg[1];
                    result_next.pos_z     = val_reg[2];
                    result_next.yaw_now   = val_reg[3];
                    result_next.pitch_now = val_reg[4];
                    result_next.roll_now  = val_reg[5];
                    result_next.done_res  = finished_reg;
                    result_valid_next     = 1'b1;
                    state_next            = kti_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kti_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TR; i++)
            begin
                idx_reg[i] <= '0;
                val_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            clock_reg        <= '0;
            running_reg      <= 1'b0;
            finished_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            t_reg            <= '0;
            step_reg         <= '0;
            walk_reg         <= 1'b0;
        end
        else
        begin
            idx_reg          <= idx_next;
            val_reg          <= val_next;
            clock_reg        <= clock_next;
            running_reg      <= running_next;
            finished_reg     <= finished_next;
            result_valid_reg <= result_valid_next;
            t_reg            <= t_next;
            step_reg         <= step_next;
            walk_reg         <= walk_next;
            if (cfg_we && (int'(cfg_index) < TR))
            begin
                cnt_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        elapsed_reg <= elapsed_next;
        now_reg     <= now_next;
        d_reg       <= d_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        num_reg     <= num_next;
        part_reg    <= part_next;
        result_reg  <= result_next;
    end

endmodule
`default_nettype wire

/* rtl/kti_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module kti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* bench/tb_keyframe_track_interpolator.sv */
// Self-checking testbench of the keyframe track interpolator.
`timescale 1ns / 100ps
`default_nettype none
module tb_keyframe_track_interpolator;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    kti_pkg::item_t item;
    logic result_valid;
    logic result_stall;
    kti_pkg::result_t result;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [kti_pkg::COUNT_W-1:0] cfg_data;

    keyframe_track_interpolator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Items waiting for the driver, and the track results still owed by the block.
    kti_pkg::item_t pending_items[$];
    kti_pkg::result_t owed_results[$];
    int fails = 0;
    int cycles = 0;
    // When set, neither side idles; long stretches of full-rate traffic.
    bit no_idle = 0;

    // Shadow copy of the block: keyframe store, counts and track state.
    logic [kti_pkg::TIME_W-1:0] shadow_time[kti_pkg::TRACKS][kti_pkg::KEYS_PER_TRACK];
    logic signed [kti_pkg::VAL_W-1:0] shadow_key[kti_pkg::TRACKS][kti_pkg::KEYS_PER_TRACK];
    logic [kti_pkg::COUNT_W-1:0] shadow_count[kti_pkg::TRACKS];
    logic [kti_pkg::COUNT_W-1:0] shadow_index[kti_pkg::TRACKS];
    logic signed [kti_pkg::VAL_W-1:0] shadow_value[kti_pkg::TRACKS];
    logic [kti_pkg::CLOCK_W-1:0] shadow_clock;
    bit shadow_running;
    bit shadow_finished;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Counts above the track depth act as the full depth.
    function automatic int usable_keys(input int tr);
        return (shadow_count[tr] > kti_pkg::KEYS_PER_TRACK) ? kti_pkg::KEYS_PER_TRACK
                                                            : int'(shadow_count[tr]);
    endfunction

    // Load channels name pitch before yaw, the tracks hold yaw before pitch.
    function automatic int channel_track(input logic [2:0] ch);
        case (ch)
            3'd3:    return 4;
            3'd4:    return 3;
            3'd6,
            3'd7:    return -1;
            default: return int'(ch);
        endcase
    endfunction

    // Advance one track by the given number of ms: pass every due key, then move a
    // fraction of the way toward the next one.
    task automatic advance_track(input int tr, input logic [kti_pkg::ELAPSED_W-1:0] ms);
        longint rem;
        longint now;
        longint key_dist;
        longint target;
        longint cur;
        bit stop;
        int k;
        rem = longint'(ms);
        now = longint'(shadow_clock);
        stop = 0;
        while (!stop && int'(shadow_index[tr]) < usable_keys(tr) && rem > 0)
        begin
            k = int'(shadow_index[tr]);
            target = longint'(shadow_key[tr][k]);
            key_dist = longint'(shadow_time[tr][k]) - now;
            if (key_dist <= 0)
            begin
                shadow_value[tr] = kti_pkg::VAL_W'(target);
                shadow_index[tr] = shadow_index[tr] + 1'b1;
            end
            else if (key_dist == rem)
            begin
                shadow_value[tr] = kti_pkg::VAL_W'(target);
                shadow_index[tr] = shadow_index[tr] + 1'b1;
                stop = 1;
            end
            else if (key_dist > rem)
            begin
                cur = longint'(shadow_value[tr]);
                shadow_value[tr] = kti_pkg::VAL_W'(cur + ((target - cur) * rem) / key_dist);
                stop = 1;
            end
            else
            begin
                shadow_value[tr] = kti_pkg::VAL_W'(target);
                shadow_index[tr] = shadow_index[tr] + 1'b1;
                rem = rem - key_dist;
                now = now + key_dist;
            end
        end
    endtask

    // Apply one accepted item to the shadow state and queue the result it owes.
    task automatic apply_item(input kti_pkg::item_t it);
        kti_pkg::result_t r;
        bit all_done;
        int tr;
        case (kti_pkg::mode_t'(it.mode))
            kti_pkg::MODE_TICK:
            begin
                if (shadow_running && !shadow_finished)
                begin
                    for (int t = 0; t < kti_pkg::TRACKS; t++)
                        advance_track(t, it.elapsed_ms);
                    shadow_clock = shadow_clock + kti_pkg::CLOCK_W'(it.elapsed_ms);
                end
                all_done = 1;
                for (int t = 0; t < kti_pkg::TRACKS; t++)
                    if (int'(shadow_index[t]) < usable_keys(t))
                        all_done = 0;
                if (all_done)
                    shadow_finished = 1;
            end
            kti_pkg::MODE_LOAD:
            begin
                tr = channel_track(it.channel);
                if (tr >= 0)
                begin
                    shadow_time[tr][it.key_index] = it.key_time;
                    shadow_key[tr][it.key_index] = it.key_value;
                end
            end
            default:
            begin
                if (kti_pkg::mode_t'(it.mode) == kti_pkg::MODE_REWIND)
                    for (int t = 0; t < kti_pkg::TRACKS; t++)
                        shadow_index[t] = '0;
                shadow_clock = '0;
                shadow_finished = 0;
                shadow_running = 1;
            end
        endcase
        r.pos_x = shadow_value[0];
        r.pos_y = shadow_value[1];
        r.pos_z = shadow_value[2];
        r.yaw_now = shadow_value[3];
        r.pitch_now = shadow_value[4];
        r.roll_now = shadow_value[5];
        r.done_res = shadow_finished;
        owed_results.push_back(r);
    endtask

    task automatic report(input string field, input longint want, input longint got);
        $display("%0d: %s expected %0d got %0d", cycles, field, want, got);
        fails++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: offers the next pending item after a random gap and keeps it steady
    // until the transfer takes place.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                apply_item(item);
                send_gap = gap_length();
            end
            if (!item_valid || !item_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls the result side at random and checks each result transfer.
    int hold_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        kti_pkg::result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_gap = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0d: result transfer with nothing owed", cycles);
                    fails++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (result.pos_x !== want.pos_x)
                        report("pos_x", want.pos_x, result.pos_x);
                    if (result.pos_y !== want.pos_y)
                        report("pos_y", want.pos_y, result.pos_y);
                    if (result.pos_z !== want.pos_z)
                        report("pos_z", want.pos_z, result.pos_z);
                    if (result.yaw_now !== want.yaw_now)
                        report("yaw_now", want.yaw_now, result.yaw_now);
                    if (result.pitch_now !== want.pitch_now)
                        report("pitch_now", want.pitch_now, result.pitch_now);
                    if (result.roll_now !== want.roll_now)
                        report("roll_now", want.roll_now, result.roll_now);
                    if (result.done_res !== want.done_res)
                        report("done_res", want.done_res, result.done_res);
                end
            end
            if (hold_gap > 0)
            begin
                hold_gap--;
                result_stall <= 1'b1;
            end
            else
            begin
                hold_gap = gap_length();
                result_stall <= (hold_gap > 0);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("keyframe_track_interpolator: mismatch");
            $finish;
        end
    end

    function automatic kti_pkg::item_t build_item(input kti_pkg::mode_t m, input int ch,
                                                  input int k, input int tm,
                                                  input int v, input int ms);
        kti_pkg::item_t it;
        it.mode = m;
        it.channel = 3'(ch);
        it.key_index = 6'(k);
        it.key_time = kti_pkg::TIME_W'(tm);
        it.key_value = kti_pkg::VAL_W'(v);
        it.elapsed_ms = kti_pkg::ELAPSED_W'(ms);
        return it;
    endfunction

    // Channel that loads a given track, the inverse of the yaw and pitch swap.
    function automatic int track_channel(input int tr);
        case (tr)
            3:       return 4;
            4:       return 3;
            default: return tr;
        endcase
    endfunction

    // Keys are spaced about 300 ms apart so that ticks of a few hundred ms walk the
    // tracks; a few loads land anywhere in time.
    function automatic int key_time_for(input int k);
        if ($urandom_range(0, 19) == 0)
            return int'($urandom_range(0, 16777215));
        return k * 300 + int'($urandom_range(0, 299));
    endfunction

    function automatic kti_pkg::item_t random_item();
        int pick;
        int k;
        int ms;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, 63);
        if (pick < 55)
        begin
            case ($urandom_range(0, 9))
                0:       ms = 0;
                1:       ms = $urandom_range(0, 65535);
                2:       ms = 65535;
                default: ms = $urandom_range(1, 700);
            endcase
            return build_item(kti_pkg::MODE_TICK, $urandom, $urandom, $urandom, $urandom, ms);
        end
        if (pick < 80)
            return build_item(kti_pkg::MODE_LOAD,
                              ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                              : $urandom_range(0, 5), k, key_time_for(k), $urandom,
                              $urandom);
        if (pick < 88)
            return build_item(kti_pkg::MODE_START, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
        return build_item(kti_pkg::MODE_REWIND, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
    endfunction

    // Wait until every item is sent and every result is back, then let the block settle.
    task automatic wait_idle();
        while (pending_items.size() > 0 || item_valid || owed_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_counts(input int c0, input int c1, input int c2,
                                input int c3, input int c4, input int c5);
        int vals[kti_pkg::TRACKS];
        vals = '{c0, c1, c2, c3, c4, c5};
        for (int i = 0; i < kti_pkg::TRACKS; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= kti_pkg::COUNT_W'(vals[i]);
            shadow_count[i] = kti_pkg::COUNT_W'(vals[i]);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        item_valid = 1'b0;
        result_stall = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        for (int t = 0; t < kti_pkg::TRACKS; t++)
        begin
            shadow_count[t] = '0;
            shadow_index[t] = '0;
            shadow_value[t] = '0;
        end
        shadow_clock = '0;
        shadow_running = 0;
        shadow_finished = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // A tick before any start moves nothing but still sets the finished flag,
        // since every count is zero.
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 100));

        // Fill every slot so that no count can reach a key that was never loaded.
        no_idle = 1;
        for (int t = 0; t < kti_pkg::TRACKS; t++)
            for (int k = 0; k < kti_pkg::KEYS_PER_TRACK; k++)
                pending_items.push_back(build_item(kti_pkg::MODE_LOAD, track_channel(t), k,
                                                   key_time_for(k), $urandom, $urandom));
        wait_idle();
        no_idle = 0;

        // Directed: extreme times and values, ignored channels, a key already due, a
        // tick that lands exactly on a key, the longest and the empty tick.
        write_counts(3, 3, 3, 3, 3, 3);
        pending_items.push_back(build_item(kti_pkg::MODE_LOAD, 0, 0, 0, 32'h7fffffff, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_LOAD, 1, 0, 100, 32'h80000000, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_LOAD, 1, 1, 200, 32'h7fffffff, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_LOAD, 3, 0, 50, 32'h00010000, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_LOAD, 4, 0, 80, 32'hffff0000, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_LOAD, 6, 0, 1, 32'h12345678, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_LOAD, 7, 1, 1, 32'h12345678, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_LOAD, 5, 63, 24'hffffff,
                                           32'h80000000, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_LOAD, 2, 2, 24'hffffff,
                                           32'h7fffffff, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_REWIND, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 100));
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 37));
        pending_items.push_back(build_item(kti_pkg::MODE_START, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 1));
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 16'hffff));
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 16'hffff));
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 5));
        pending_items.push_back(build_item(kti_pkg::MODE_REWIND, 0, 0, 0, 0, 0));
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 250));
        wait_idle();

        // Lowering a count below the index makes that track exhausted at once.
        write_counts(1, 0, 2, 0, 1, 0);
        pending_items.push_back(build_item(kti_pkg::MODE_TICK, 0, 0, 0, 0, 10));
        wait_idle();

        // Random phases over a spread of count settings, full depth and saturation
        // among them.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       write_counts(64, 64, 64, 64, 64, 64);
                1:       write_counts(127, 127, 127, 127, 127, 127);
                2:       write_counts(0, 0, 0, 0, 0, 0);
                3:       write_counts(1, 2, 3, 4, 5, 6);
                4:       write_counts(65, 0, 64, 1, 100, 7);
                default: write_counts($urandom_range(0, 127), $urandom_range(0, 20),
                                      $urandom_range(0, 20), $urandom_range(0, 70),
                                      $urandom_range(0, 10), $urandom_range(0, 127));
            endcase
            no_idle = (phase == 3);
            pending_items.push_back(build_item(kti_pkg::MODE_REWIND, 0, 0, 0, 0, 0));
            for (int n = 0; n < 50; n++)
                pending_items.push_back(random_item());
            wait_idle();
        end
        no_idle = 0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("keyframe_track_interpolator: match");
        else
            $display("keyframe_track_interpolator: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
